@@ design/jpdt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpdt_pkg: shared types and constants
// Constants, register indexes and the records that travel through the
// joint PD torque block.
// ----------------------------------------------------------------------------
package jpdt_pkg;

  localparam int MAX_JOINTS_DEF = 32;
  localparam int CMD_SLOTS      = 29;
  localparam int QUEUE_DEPTH    = 4;
  localparam int DIV_STEPS      = 32;

  localparam logic [7:0]  SERVO_MODE = 8'h01;
  localparam logic [29:0] NS_PER_S   = 30'd1000000000;

  localparam logic [5:0]  JOINT_COUNT_RST  = 6'd0;
  localparam logic [31:0] HOLD_STIFF_RST   = 32'd6553600;  // 100.0 in Q16.16
  localparam logic [31:0] HOLD_DAMP_RST    = 32'd655360;   // 10.0 in Q16.16
  localparam logic [31:0] MIN_INTERVAL_RST = 32'd1000;

  typedef enum logic [1:0] {
    REG_JOINT_COUNT  = 2'd0,
    REG_HOLD_STIFF   = 2'd1,
    REG_HOLD_DAMP    = 2'd2,
    REG_MIN_INTERVAL = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [5:0]  joint_count;
    logic [31:0] hold_stiffness;
    logic [31:0] hold_damping;
    logic [31:0] min_interval_ns;
  } cfg_t;

  // Work common to every back-end stage.
  typedef struct packed {
    logic        jv;        // joint accepted
    logic        neg;       // position change is negative
    logic [31:0] interval;  // divisor, never zero
    logic [32:0] diff_a;    // signed position error
    logic [31:0] gain_a;    // position gain
    logic [31:0] gain_b;    // damping gain
    logic [31:0] dq;        // signed target velocity (zero in hold)
    logic [31:0] ff;        // signed feedforward (zero in hold)
  } ctl_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [32:0] mag;       // magnitude of position change, zero if no estimate
  } entry_t;

endpackage

@@ design/joint_pd_torque_with_hold.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_pd_torque_with_hold: joint PD torque with idle position hold
// Estimates joint velocity from successive position samples and produces a
// servo PD torque with feedforward, or a hold torque toward the position
// captured on the joint's first visit if it is idle, else zero.
//
//   Channel  Direction  Handshake              Payload
//   in_      inbound    in_valid / in_stall    joint sample and command
//   out_     outbound   out_valid / out_stall  torque, velocity, joint valid
//   cfg_     inbound    APB psel/penable       four 32-bit registers
//
// One sample is accepted per cycle while the queue has room. From the queue
// a sample moves into stage 0, two operand stages form the dividend, the
// 32-step restoring divider takes 33 register stages, and the velocity,
// product and output stages take three more. Per-joint state is read and
// written in the intake cycle, so samples of the same joint may follow each
// other directly. Reset is synchronous, active low; it clears the registers,
// the first-visit flags and the hold positions at once, so no clearing pass
// is needed. A stalled output freezes the whole arithmetic pipeline; the
// four-entry queue absorbs intake until it fills, and only then is in_stall
// raised.
// ----------------------------------------------------------------------------
module joint_pd_torque_with_hold import jpdt_pkg::*; #(
  parameter int MAX_JOINTS = MAX_JOINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_joint_index,
  input  logic [31:0] in_measured_position,
  input  logic [31:0] in_interval_ns,
  input  logic [7:0]  in_command_mode,
  input  logic [31:0] in_target_position,
  input  logic [31:0] in_target_velocity,
  input  logic [31:0] in_feedforward_torque,
  input  logic [31:0] in_stiffness_gain,
  input  logic [31:0] in_damping_gain,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_joint_torque,
  output logic [31:0] out_velocity_estimate,
  output logic        out_joint_valid,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t   cfg;
  entry_t f_entry, q_head;
  logic   q_full, q_nonempty, q_pop, accept;

  // A transfer is taken whenever the queue has room.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  jpdt_regs u_regs (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .cfg
  );

  jpdt_front #(.MAX_JOINTS(MAX_JOINTS)) u_front (
    .clk, .rst_n, .accept,
    .joint_index        (in_joint_index),
    .measured_position  (in_measured_position),
    .interval_ns        (in_interval_ns),
    .command_mode       (in_command_mode),
    .target_position    (in_target_position),
    .target_velocity    (in_target_velocity),
    .feedforward_torque (in_feedforward_torque),
    .stiffness_gain     (in_stiffness_gain),
    .damping_gain       (in_damping_gain),
    .cfg,
    .entry              (f_entry)
  );

  jpdt_queue u_queue (
    .clk, .rst_n,
    .push     (accept),
    .wdata    (f_entry),
    .pop      (q_pop),
    .rdata    (q_head),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  jpdt_back u_back (
    .clk, .rst_n,
    .q_nonempty,
    .q_data  (q_head),
    .q_pop,
    .out_stall, .out_valid, .out_joint_torque, .out_velocity_estimate,
    .out_joint_valid
  );

endmodule

@@ design/jpdt_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpdt_regs: configuration registers
// APB-style register file holding the joint count, hold gains and the
// minimum interval.
// ----------------------------------------------------------------------------
module jpdt_regs import jpdt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output cfg_t        cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.joint_count     <= JOINT_COUNT_RST;
      cfg_r.hold_stiffness  <= HOLD_STIFF_RST;
      cfg_r.hold_damping    <= HOLD_DAMP_RST;
      cfg_r.min_interval_ns <= MIN_INTERVAL_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_JOINT_COUNT:  cfg_r.joint_count     <= cfg_pwdata[5:0];
        REG_HOLD_STIFF:   cfg_r.hold_stiffness  <= cfg_pwdata;
        REG_HOLD_DAMP:    cfg_r.hold_damping    <= cfg_pwdata;
        REG_MIN_INTERVAL: cfg_r.min_interval_ns <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_JOINT_COUNT:  cfg_prdata = {26'd0, cfg_r.joint_count};
      REG_HOLD_STIFF:   cfg_prdata = cfg_r.hold_stiffness;
      REG_HOLD_DAMP:    cfg_prdata = cfg_r.hold_damping;
      REG_MIN_INTERVAL: cfg_prdata = cfg_r.min_interval_ns;
      default:          cfg_prdata = 32'd0;
    endcase
  end

endmodule

@@ design/jpdt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpdt_front: sample intake and classification
// Checks the joint, reads and updates per-joint state, and selects the
// servo or hold operands for the back end.
// ----------------------------------------------------------------------------
module jpdt_front import jpdt_pkg::*; #(
  parameter int MAX_JOINTS = MAX_JOINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [4:0]  joint_index,
  input  logic [31:0] measured_position,
  input  logic [31:0] interval_ns,
  input  logic [7:0]  command_mode,
  input  logic [31:0] target_position,
  input  logic [31:0] target_velocity,
  input  logic [31:0] feedforward_torque,
  input  logic [31:0] stiffness_gain,
  input  logic [31:0] damping_gain,
  input  cfg_t        cfg,
  output entry_t      entry
);

  localparam int DEPTH = (MAX_JOINTS < CMD_SLOTS) ? MAX_JOINTS : CMD_SLOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DEPTH-1:0] seen_r;
  logic [31:0]      hold_r [DEPTH];
  logic [31:0]      prev_r [DEPTH];

  logic [AW-1:0] addr;
  logic          jv, seen, servo, vel_en;
  logic [31:0]   prev, hold_eff;
  logic [32:0]   diff, pos_x;

  assign addr  = joint_index[AW-1:0];
  assign jv    = ({1'b0, joint_index} < cfg.joint_count) &&
                 ({27'd0, joint_index} < 32'(DEPTH));
  assign seen  = jv && seen_r[addr];
  assign prev  = prev_r[addr];
  assign servo = (command_mode == SERVO_MODE);
  assign pos_x = {measured_position[31], measured_position};
  // On an idle first visit the captured position is the current sample.
  assign hold_eff = seen_r[addr] ? hold_r[addr] : measured_position;
  assign vel_en   = seen && (interval_ns > cfg.min_interval_ns) && (interval_ns != 32'd0);
  assign diff     = pos_x - {prev[31], prev};

  always_comb begin
    entry.mag          = !vel_en ? 33'd0 : (diff[32] ? 33'd0 - diff : diff);
    entry.ctl.jv       = jv;
    entry.ctl.neg      = diff[32];
    entry.ctl.interval = vel_en ? interval_ns : 32'd1;
    if (servo) begin
      entry.ctl.diff_a = {target_position[31], target_position} - pos_x;
      entry.ctl.gain_a = stiffness_gain;
      entry.ctl.gain_b = damping_gain;
      entry.ctl.dq     = target_velocity;
      entry.ctl.ff     = feedforward_torque;
    end else begin
      entry.ctl.diff_a = {hold_eff[31], hold_eff} - pos_x;
      entry.ctl.gain_a = cfg.hold_stiffness;
      entry.ctl.gain_b = cfg.hold_damping;
      entry.ctl.dq     = 32'd0;
      entry.ctl.ff     = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      for (int i = 0; i < DEPTH; i++) hold_r[i] <= 32'd0;
    end else if (accept && jv) begin
      seen_r[addr] <= 1'b1;
      if (!seen_r[addr] && !servo) hold_r[addr] <= measured_position;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && jv) prev_r[addr] <= measured_position;
  end

endmodule

@@ design/jpdt_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpdt_queue: front-to-back queue
// Short FIFO that lets the intake and the arithmetic pipeline stall apart.
// ----------------------------------------------------------------------------
module jpdt_queue import jpdt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t wdata,
  input  logic   pop,
  output entry_t rdata,
  output logic   full,
  output logic   nonempty
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  entry_t        mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full     = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign rdata    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

@@ design/jpdt_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpdt_back: arithmetic pipeline
// Scales the position change, divides by the interval one quotient bit per
// stage, then forms the PD torque and saturates it.
// ----------------------------------------------------------------------------
module jpdt_back import jpdt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_nonempty,
  input  entry_t      q_data,
  output logic        q_pop,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [31:0] out_joint_torque,
  output logic [31:0] out_velocity_estimate,
  output logic        out_joint_valid
);

  logic adv;

  // Stage 0: head of queue. Stage 1: partial products. Stage 2: dividend.
  logic        s0_v_r, s1_v_r, s2_v_r;
  entry_t      s0_r;
  ctl_t        s1_c_r, s2_c_r;
  logic [46:0] s1_lo_r;
  logic [45:0] s1_hi_r;
  logic [62:0] s2_div_r;

  // Division stages.
  logic        d_v_r   [DIV_STEPS+1];
  ctl_t        d_c_r   [DIV_STEPS+1];
  logic [31:0] d_rem_r [DIV_STEPS+1];
  logic [31:0] d_acc_r [DIV_STEPS+1];
  logic        d_ovf_r [DIV_STEPS+1];

  // Velocity, product and output stages.
  logic        v_v_r, m_v_r;
  ctl_t        v_c_r;
  logic [31:0] v_vel_r;
  logic [64:0] m_pa_r, m_pb_r;
  logic        m_na_r, m_nb_r, m_jv_r;
  logic [31:0] m_ff_r, m_vel_r;

  logic        out_valid_r, out_jv_r;
  logic [31:0] out_tq_r, out_vel_r;

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && q_nonempty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      d_v_r[0] <= 1'b0;
    end else if (adv) begin
      s0_v_r <= q_nonempty;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
      d_v_r[0] <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r       <= q_data;
      s1_c_r     <= s0_r.ctl;
      s1_lo_r    <= 47'(s0_r.mag[16:0] * NS_PER_S);
      s1_hi_r    <= 46'(s0_r.mag[32:17] * NS_PER_S);
      s2_c_r     <= s1_c_r;
      s2_div_r   <= {16'd0, s1_lo_r} + {s1_hi_r, 17'd0};
      d_c_r[0]   <= s2_c_r;
      d_ovf_r[0] <= ({1'b0, s2_div_r[62:32]} >= s2_c_r.interval);
      d_rem_r[0] <= {1'b0, s2_div_r[62:32]};
      d_acc_r[0] <= s2_div_r[31:0];
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [32:0] trial;
    logic        ge;
    assign trial = {d_rem_r[k], d_acc_r[k][31]};
    assign ge    = (trial >= {1'b0, d_c_r[k].interval});

    always_ff @(posedge clk) begin
      if (!rst_n) d_v_r[k+1] <= 1'b0;
      else if (adv) d_v_r[k+1] <= d_v_r[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_c_r[k+1]   <= d_c_r[k];
        d_ovf_r[k+1] <= d_ovf_r[k];
        d_rem_r[k+1] <= ge ? 32'(trial - {1'b0, d_c_r[k].interval}) : trial[31:0];
        d_acc_r[k+1] <= {d_acc_r[k][30:0], ge};
      end
    end
  end

  // Saturate the quotient with the sign of the position change.
  logic [31:0] q, vel;
  assign q = d_acc_r[DIV_STEPS];
  always_comb begin
    if (d_c_r[DIV_STEPS].neg) begin
      if (d_ovf_r[DIV_STEPS] || (q[31] && q[30:0] != 31'd0)) vel = 32'h8000_0000;
      else vel = 32'd0 - q;
    end else begin
      if (d_ovf_r[DIV_STEPS] || q[31]) vel = 32'h7FFF_FFFF;
      else vel = q;
    end
  end

  logic [32:0] a_mag, bd, b_mag;
  assign a_mag = v_c_r.diff_a[32] ? 33'd0 - v_c_r.diff_a : v_c_r.diff_a;
  assign bd    = {v_c_r.dq[31], v_c_r.dq} - {v_vel_r[31], v_vel_r};
  assign b_mag = bd[32] ? 33'd0 - bd : bd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_v_r       <= 1'b0;
      m_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_v_r       <= d_v_r[DIV_STEPS];
      m_v_r       <= v_v_r;
      out_valid_r <= m_v_r;
    end
  end

  logic [51:0] ta, tb, sum;
  assign ta  = m_na_r ? 52'd0 - {3'd0, m_pa_r[64:16]} : {3'd0, m_pa_r[64:16]};
  assign tb  = m_nb_r ? 52'd0 - {3'd0, m_pb_r[64:16]} : {3'd0, m_pb_r[64:16]};
  assign sum = {{20{m_ff_r[31]}}, m_ff_r} + ta + tb;

  logic [31:0] tq_sat;
  always_comb begin
    if (!sum[51] && sum[50:31] != 20'd0)        tq_sat = 32'h7FFF_FFFF;
    else if (sum[51] && sum[50:31] != 20'hFFFFF) tq_sat = 32'h8000_0000;
    else                                         tq_sat = sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v_c_r     <= d_c_r[DIV_STEPS];
      v_vel_r   <= vel;
      m_pa_r    <= v_c_r.gain_a * a_mag;
      m_pb_r    <= v_c_r.gain_b * b_mag;
      m_na_r    <= v_c_r.diff_a[32];
      m_nb_r    <= bd[32];
      m_jv_r    <= v_c_r.jv;
      m_ff_r    <= v_c_r.ff;
      m_vel_r   <= v_vel_r;
      out_jv_r  <= m_jv_r;
      out_tq_r  <= m_jv_r ? tq_sat : 32'd0;
      out_vel_r <= m_jv_r ? m_vel_r : 32'd0;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_joint_torque      = out_tq_r;
  assign out_velocity_estimate = out_vel_r;
  assign out_joint_valid       = out_jv_r;

endmodule

@@ design/jpdt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpdt_checker: port-level checks
// Watches the top-level ports for output holding, rejected-joint results,
// reset behavior and the register port's ready.
// ----------------------------------------------------------------------------
module jpdt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_joint_torque,
  input logic [31:0] out_velocity_estimate,
  input logic        out_joint_valid,
  input logic        cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_joint_torque) &&
      $stable(out_velocity_estimate) && $stable(out_joint_valid))
    else $error("stalled result changed");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_joint_valid |->
      out_joint_torque == 32'd0 && out_velocity_estimate == 32'd0)
    else $error("rejected joint gave nonzero result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("register port not ready");

endmodule

bind joint_pd_torque_with_hold jpdt_checker u_jpdt_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_joint_torque,
  .out_velocity_estimate, .out_joint_valid, .cfg_pready
);
